FILE: hw/rtl/ges_pkg.sv
// shared constants for the grounded extension solver
`timescale 1ns / 1ps
`default_nettype none

package ges_pkg;

	localparam int MAX_ARGS = 64;
	localparam int ROW_W    = 64;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int ADDR_W   = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_SOLVE = 1'b1;

endpackage

`default_nettype wire

FILE: hw/rtl/ges_cmd_if.sv
// command channel: attack row loads and solve requests
`timescale 1ns / 1ps
`default_nettype none

interface ges_cmd_if;
	import ges_pkg::*;

	logic             valid;
	logic             ready;
	logic             func;
	logic [IDX_W-1:0] arg_index;
	logic [ROW_W-1:0] attack_row;

	modport source (output valid, output func, output arg_index, output attack_row,
		input ready);
	modport sink (input valid, input func, input arg_index, input attack_row,
		output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ges_ext_if.sv
// result channel: grounded extension bitmap and its size
`timescale 1ns / 1ps
`default_nettype none

interface ges_ext_if;
	import ges_pkg::*;

	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] in_set;
	logic [CNT_W-1:0] in_count;

	modport source (output valid, output in_set, output in_count, input ready);
	modport sink (input valid, input in_set, input in_count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ges_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ges_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/grounded_extension_solver_top.sv
// grounded extension solver top level
// usage:
//   cfg_we/cfg_wdata write arg_count (number of live arguments) while idle.
//   cmd carries one item: func load writes attack_row into row arg_index of
//   the attack store, func solve computes the grounded extension of rows and
//   columns below arg_count and returns one item on ext (in_set, in_count).
// solve passes:
//   a solve runs passes over the stored rows through one shared
//   or-accumulate unit, one row per cycle from the row ram, over n = arg_count
//   rows capped at 64, with no pass for n zero. passes repeat until one
//   changes no label. each changing pass adds a label, so P <= n+1
//   passes. cmd.ready is high only while no solve runs.
// reset:
//   arst_n clears arg_count, the label bitmaps and all control state; the
//   row ram is not cleared and rows must be loaded before they are solved.
// stall:
//   the result waits in an output register; loads are still taken meanwhile,
//   and a following solve finishes its passes and holds until ext is free.
`timescale 1ns / 1ps
`default_nettype none

module grounded_extension_solver_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [ges_pkg::CNT_W-1:0] cfg_wdata,
	ges_cmd_if.sink                    cmd,
	ges_ext_if.source                  ext
);
	import ges_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PASS = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_EVAL = 2'd3;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  arg_count_q;
	logic [CNT_W-1:0]  n_eff;
	logic [ROW_W-1:0]  mask;
	logic [ROW_W-1:0]  in_q;
	logic [ROW_W-1:0]  out_q;
	logic [ROW_W-1:0]  threat_q;
	logic [ROW_W-1:0]  hit_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] idx_s1;
	logic              vld_s1;
	logic              ext_valid_q;
	logic [ROW_W-1:0]  in_set_q;
	logic [CNT_W-1:0]  in_count_q;

	logic              cmd_acc;
	logic              load_we;
	logic [ROW_W-1:0]  rdata;
	logic [ROW_W-1:0]  row_m;
	logic [ROW_W-1:0]  out_new;
	logic [ROW_W-1:0]  in_new;
	logic              changed;
	logic              last_idx;
	logic              emit;

	assign n_eff = (arg_count_q > CNT_W'(MAX_ARGS)) ? CNT_W'(MAX_ARGS) : arg_count_q;

	always_comb begin
		for (int b = 0; b < ROW_W; b++) begin
			mask[b] = (CNT_W'(b) < n_eff);
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign load_we   = cmd_acc && (cmd.func == FUNC_LOAD)
		&& ({1'b0, cmd.arg_index} < CNT_W'(MAX_ARGS));

	ges_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_ARGS)
	) u_rows (
		.clk   (clk),
		.we    (load_we),
		.waddr (cmd.arg_index[ADDR_W-1:0]),
		.wdata (cmd.attack_row),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign row_m    = rdata & mask;
	assign out_new  = out_q | (hit_q & mask);
	assign in_new   = in_q | (mask & ~threat_q & ~out_new);
	assign changed  = (in_new != in_q) || (out_new != out_q);
	assign last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == n_eff);
	assign emit     = (state_q == ST_EVAL) && !changed && (!ext_valid_q || ext.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_count_q <= '0;
		end else if (cfg_we) begin
			arg_count_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			in_q        <= '0;
			out_q       <= '0;
			ext_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				ext_valid_q <= 1'b1;
			end else if (ext.ready) begin
				ext_valid_q <= 1'b0;
			end
			vld_s1 <= (state_q == ST_PASS);
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc && (cmd.func == FUNC_SOLVE)) begin
						in_q  <= '0;
						out_q <= '0;
						idx_q <= '0;
						state_q <= (n_eff == '0) ? ST_EVAL : ST_PASS;
					end
				end
				ST_PASS: begin
					if (last_idx) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
				ST_LAST: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (changed) begin
						in_q    <= in_new;
						out_q   <= out_new;
						idx_q   <= '0;
						state_q <= ST_PASS;
					end else if (!ext_valid_q || ext.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if ((state_q == ST_IDLE) || ((state_q == ST_EVAL) && changed)) begin
			threat_q <= '0;
			hit_q    <= '0;
			cnt_q    <= '0;
		end else if (vld_s1) begin
			if (!out_q[idx_s1]) begin
				threat_q <= threat_q | row_m;
			end
			if (in_q[idx_s1]) begin
				hit_q <= hit_q | row_m;
			end
			cnt_q <= cnt_q + CNT_W'(in_q[idx_s1]);
		end
		if (emit) begin
			in_set_q   <= in_q;
			in_count_q <= cnt_q;
		end
	end

	assign ext.valid    = ext_valid_q;
	assign ext.in_set   = in_set_q;
	assign ext.in_count = in_count_q;

	a_labels_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(in_q & out_q) == '0)
		else $error("argument labelled both in and out");

	a_labels_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (((in_q | out_q) & ~mask) == '0))
		else $error("label set beyond argument count");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS) |-> (CNT_W'(idx_q) < n_eff))
		else $error("row index beyond argument count");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ext_valid_q) |-> (32'(in_count_q) == $countones(in_set_q)))
		else $error("in_count does not match in_set");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 || (state_q == ST_LAST)) |-> !cmd.ready)
		else $error("item taken during a pass");

endmodule

`default_nettype wire

FILE: verif/ges_ext_checker.sv
// checker for the grounded extension solver: watches both channels, predicts each solve, compares
`timescale 1ns / 1ps

module ges_ext_checker
	import ges_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	ges_cmd_if               cmd,
	ges_ext_if               ext,
	output int unsigned      errors,
	output int unsigned      waiting
);

	typedef struct packed {
		logic [ROW_W-1:0] in_set;
		logic [CNT_W-1:0] in_count;
	} extension_t;

	logic [ROW_W-1:0] atk_rows [MAX_ARGS];
	logic [CNT_W-1:0] live_n;
	extension_t       ext_due [$];

	task automatic report_mismatch(input string what, input logic [ROW_W-1:0] got,
		input logic [ROW_W-1:0] want);
		$display("%0t mismatch on %s: got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	// fixed-point labelling over the first n arguments
	function automatic logic [ROW_W-1:0] grounded_set(input int unsigned n);
		logic [ROW_W-1:0] mask, in_b, out_b, hit, sub;
		int unsigned owed [MAX_ARGS];
		bit moved;
		int i, j, k;
		mask = (n >= ROW_W) ? '1 : ((64'd1 << n) - 64'd1);
		in_b = '0;
		out_b = '0;
		for (i = 0; i < n; i++) begin
			owed[i] = 0;
			for (j = 0; j < n; j++)
				owed[i] += atk_rows[j][i];
		end
		moved = 1'b1;
		while (moved) begin
			moved = 1'b0;
			for (i = 0; i < n; i++) begin
				if (in_b[i] || out_b[i] || owed[i] != 0)
					continue;
				in_b[i] = 1'b1;
				moved = 1'b1;
				hit = atk_rows[i] & mask;
				for (j = 0; j < n; j++) begin
					if (!hit[j] || out_b[j])
						continue;
					out_b[j] = 1'b1;
					in_b[j] = 1'b0;
					sub = atk_rows[j] & mask;
					for (k = 0; k < n; k++)
						if (sub[k] && owed[k] != 0)
							owed[k]--;
				end
			end
		end
		return in_b;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		extension_t due;
		if (!arst_n) begin
			live_n = '0;
			foreach (atk_rows[r])
				atk_rows[r] = '0;
			ext_due.delete();
		end else begin
			// results first, so a solve taken this cycle cannot match them
			if (ext.valid && ext.ready) begin
				if (ext_due.size() == 0) begin
					report_mismatch("result with none expected", ext.in_set, '0);
				end else begin
					due = ext_due.pop_front();
					if (ext.in_set !== due.in_set)
						report_mismatch("in_set", ext.in_set, due.in_set);
					if (ext.in_count !== due.in_count)
						report_mismatch("in_count", ROW_W'(ext.in_count), ROW_W'(due.in_count));
				end
			end
			if (cfg_we)
				live_n = cfg_wdata;
			if (cmd.valid && cmd.ready) begin
				if (cmd.func == FUNC_LOAD) begin
					atk_rows[cmd.arg_index] = cmd.attack_row;
				end else begin
					due.in_set = grounded_set((live_n > MAX_ARGS) ? MAX_ARGS : live_n);
					due.in_count = CNT_W'($countones(due.in_set));
					ext_due = {ext_due, due};
				end
			end
		end
		waiting = ext_due.size();
	end

endmodule

FILE: verif/grounded_extension_solver_top_tb.sv
// testbench top for the grounded extension solver: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module grounded_extension_solver_top_tb;
	import ges_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned PHASE_ITEMS = 100;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	int unsigned      errors;
	int unsigned      waiting;
	int unsigned      cycles;
	int unsigned      arg_n_now;
	logic [MAX_ARGS-1:0] rows_seen;
	bit               quiet;
	bit               long_hold;

	ges_cmd_if cmd ();
	ges_ext_if ext ();

	grounded_extension_solver_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.ext       (ext)
	);

	ges_ext_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.ext       (ext),
		.errors    (errors),
		.waiting   (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		int unsigned held;
		ext.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				ext.ready <= 1'b0;
				held = 0;
				while (held < LONG_HOLD - 1) begin
					@(posedge clk);
					held++;
				end
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				ext.ready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(posedge clk);
			end else begin
				ext.ready <= 1'b1;
			end
		end
	end

	function automatic int unsigned live_span(input int unsigned n);
		if (n == 0)
			return 1;
		return (n > MAX_ARGS) ? MAX_ARGS : n;
	endfunction

	// mostly sparse graphs so labelling runs several passes
	function automatic logic [ROW_W-1:0] attack_pattern(input int unsigned idx,
		input int unsigned n);
		logic [ROW_W-1:0] r, junk;
		int unsigned span;
		span = live_span(n);
		r = '0;
		junk = (span >= ROW_W) ? '0 : ~((64'd1 << span) - 64'd1);
		case ($urandom_range(0, 9))
			0: r = '0;
			1: r = '1;
			2: r = {$urandom, $urandom};
			3: r[$urandom_range(0, span - 1)] = 1'b1;
			4, 5, 6: begin
				repeat ($urandom_range(1, 2)) r[$urandom_range(0, span - 1)] = 1'b1;
			end
			7: r[(idx + 1) % ROW_W] = 1'b1;
			8: r[idx % ROW_W] = 1'b1;
			default: begin
				r[$urandom_range(0, span - 1)] = 1'b1;
				r = r | ({$urandom, $urandom} & junk);
			end
		endcase
		return r;
	endfunction

	task automatic send_item(input logic f, input logic [IDX_W-1:0] idx,
		input logic [ROW_W-1:0] row);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.func       <= f;
		cmd.arg_index  <= idx;
		cmd.attack_row <= row;
		do @(posedge clk); while (!cmd.ready);
		if (f == FUNC_LOAD)
			rows_seen[idx] = 1'b1;
	endtask

	// drop valid and wait for every expected result plus load latency
	task automatic settle_block();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_arg_count(input int unsigned n);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(n);
		@(posedge clk);
		cfg_we    <= 1'b0;
		arg_n_now = n;
	endtask

	// never solve over a row that was not loaded since reset
	task automatic request_extension();
		int unsigned i;
		for (i = 0; i < ((arg_n_now > MAX_ARGS) ? MAX_ARGS : arg_n_now); i++)
			if (!rows_seen[i])
				send_item(FUNC_LOAD, IDX_W'(i), attack_pattern(i, arg_n_now));
		send_item(FUNC_SOLVE, IDX_W'($urandom), {$urandom, $urandom});
	endtask

	initial begin
		int unsigned phase_n [16];
		int unsigned idx;
		int p, it;
		phase_n = '{1, 2, 3, 5, 127, 8, 0, 12, 4, 16, 64, 6, 31, 9, 2, 7};
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		cmd.valid      <= 1'b0;
		cmd.func       <= FUNC_LOAD;
		cmd.arg_index  <= '0;
		cmd.attack_row <= '0;
		rows_seen = '0;
		arg_n_now = 0;
		quiet = 1'b0;
		long_hold = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty framework
		write_arg_count(0);
		request_extension();
		// chain, bits beyond the count, self attack
		write_arg_count(4);
		send_item(FUNC_LOAD, 0, 64'd1 << 1);
		send_item(FUNC_LOAD, 1, 64'd1 << 2);
		send_item(FUNC_LOAD, 2, 64'hFFFF_FFFF_FFFF_FFF0);
		send_item(FUNC_LOAD, 3, 64'd1 << 3);
		request_extension();
		// mutual attack
		send_item(FUNC_LOAD, 0, 64'd1 << 1);
		send_item(FUNC_LOAD, 1, 64'd1 << 0);
		request_extension();
		// top index stored but unused, full row
		send_item(FUNC_LOAD, 63, '1);
		send_item(FUNC_LOAD, 0, '1);
		request_extension();
		// no attacks at all
		write_arg_count(2);
		send_item(FUNC_LOAD, 0, '0);
		send_item(FUNC_LOAD, 1, '0);
		request_extension();

		for (p = 0; p < 16; p++) begin
			write_arg_count(phase_n[p]);
			quiet = (p >= 14);
			if (p == 3)
				long_hold = 1'b1;
			for (it = 0; it < PHASE_ITEMS; it++) begin
				if (p == 8 && it == PHASE_ITEMS / 2)
					settle_block();
				if ($urandom_range(0, 3) == 0) begin
					request_extension();
				end else begin
					idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_ARGS - 1)
						: $urandom_range(0, live_span(arg_n_now) - 1);
					send_item(FUNC_LOAD, IDX_W'(idx), attack_pattern(idx, arg_n_now));
				end
			end
		end

		settle_block();
		repeat (12) @(posedge clk);
		if (errors == 0 && waiting == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: grounded_extension_solver_top.f
hw/rtl/ges_pkg.sv
hw/rtl/ges_cmd_if.sv
hw/rtl/ges_ext_if.sv
hw/rtl/ges_ram.sv
hw/rtl/grounded_extension_solver_top.sv
verif/ges_ext_checker.sv
verif/grounded_extension_solver_top_tb.sv
